// ----- rtl/osrs_pkg.sv -----
// Shared constants, codes and types of the ordered set rank/select block.
package osrs_pkg;

  // Store size and field widths
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned RANK_W   = 8;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned WIDE_W   = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  // Rank value reported when there is no position
  localparam logic [RANK_W-1:0] RANK_NONE = '1;

  // Request operations
  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_ERASE  = 3'd1,
    OP_FIND   = 3'd2,
    OP_LOWER  = 3'd3,
    OP_SELECT = 3'd4,
    OP_CLEAR  = 3'd5
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_NO_EFFECT = 2'd1,
    STAT_FULL      = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    CTL_IDLE = 2'd0,
    CTL_CMP  = 2'd1,
    CTL_RES  = 2'd2
  } ctl_e;

  // Command broadcast to every cell
  typedef struct packed {
    logic cmp;
    logic ins;
    logic ers;
  } cell_cmd_t;

  // Compare flags registered in each cell
  typedef struct packed {
    logic lt;
    logic eq;
    logic sel;
  } cell_flags_t;

  // Lookup summary gathered over the row
  typedef struct packed {
    logic [CNT_W-1:0]    pos;
    logic                present;
    logic [KEY_BITS-1:0] sel_key;
  } lookup_t;

endpackage

// ----- rtl/ordered_set_rank_select.sv -----
// Ordered set of distinct keys with rank and select: controller, cell row and output register.
//
// Input channel: in_valid_i/in_stall_o carry operation_i, key_i and index_i.
// A transfer happens on a rising edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o/out_stall_i carry status_o, rank_o, key_out_o
// and count_o, one result per request, in request order.
// Keys sit in ascending order in a row of CAPACITY cells; each cell compares
// its key with the request and shifts with its neighbors on insert or erase.
// An item passes through three steps: capture, the cells registering their
// compare flags, and gathering the flags to form the result and shift.
// The result is loaded into the output register as the gather step ends,
// and the next item is taken once the controller is back in idle.
// While a result waits under out_stall_i, the next item still enters and
// compares; it holds in the gather step until the output register is free.
// Reset empties the set (count zero), returns the controller to idle and
// clears the output valid flag; the key cells need no clearing since only
// cells below the count are ever read.
module ordered_set_rank_select import osrs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          operation_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [INDEX_W-1:0]  index_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [RANK_W-1:0]   rank_o,
  output logic [KEY_BITS-1:0] key_out_o,
  output logic [COUNT_W-1:0]  count_o
);

  ctl_e                state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [2:0]          op_q;
  logic [KEY_BITS-1:0] req_key_q;
  logic [INDEX_W-1:0]  req_index_q;

  logic                out_valid_q;
  logic [1:0]          status_q;
  logic [RANK_W-1:0]   rank_q;
  logic [KEY_BITS-1:0] key_out_q;
  logic [COUNT_W-1:0]  out_count_q;

  cell_cmd_t                          cmd;
  cell_flags_t [CAPACITY-1:0]         flags;
  logic        [CAPACITY-1:0][KEY_BITS-1:0] keys;
  lookup_t                            lookup;

  logic                accept;
  logic                out_free;
  logic                commit;
  logic                full;
  logic                in_range;
  logic [RANK_W-1:0]   pos_rank;
  status_e             r_status;
  logic [RANK_W-1:0]   r_rank;
  logic [KEY_BITS-1:0] r_key;
  logic                r_ins;
  logic                r_ers;
  logic [CNT_W-1:0]    r_count;

  assign in_stall_o = state_q != CTL_IDLE;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Row of cells, each linked to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0] left_key;
    logic                left_lt;
    logic [KEY_BITS-1:0] right_key;

    if (i == 0) begin : g_first
      assign left_key = req_key_q;
      assign left_lt  = 1'b1;
    end else begin : g_inner
      assign left_key = keys[i-1];
      assign left_lt  = flags[i-1].lt;
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = '0;
    end else begin : g_body
      assign right_key = keys[i+1];
    end

    osrs_cell u_cell (
      .clk_i       (clk_i),
      .cell_idx_i  (IDX_W'(i)),
      .count_i     (count_q),
      .req_key_i   (req_key_q),
      .req_index_i (req_index_q),
      .cmd_i       (cmd),
      .left_key_i  (left_key),
      .left_lt_i   (left_lt),
      .right_key_i (right_key),
      .key_o       (keys[i]),
      .flags_o     (flags[i])
    );
  end

  osrs_resolve u_resolve (
    .flags_i  (flags),
    .keys_i   (keys),
    .count_i  (count_q),
    .lookup_o (lookup)
  );

  // Form the result of the held request
  always_comb begin
    full     = count_q == CNT_W'(CAPACITY);
    in_range = WIDE_W'(req_index_q) < WIDE_W'(count_q);
    pos_rank = RANK_W'(lookup.pos);
    r_status = STAT_NO_EFFECT;
    r_rank   = RANK_NONE;
    r_key    = '0;
    r_ins    = 1'b0;
    r_ers    = 1'b0;
    r_count  = count_q;
    unique case (op_e'(op_q))
      OP_INSERT: begin
        if (lookup.present) begin
          r_rank = pos_rank;
          r_key  = req_key_q;
        end else if (full) begin
          r_status = STAT_FULL;
        end else begin
          r_status = STAT_DONE;
          r_rank   = pos_rank;
          r_key    = req_key_q;
          r_ins    = 1'b1;
          r_count  = count_q + 1'b1;
        end
      end
      OP_ERASE: begin
        if (lookup.present) begin
          r_status = STAT_DONE;
          r_rank   = pos_rank;
          r_key    = req_key_q;
          r_ers    = 1'b1;
          r_count  = count_q - 1'b1;
        end
      end
      OP_FIND: begin
        if (lookup.present) begin
          r_status = STAT_DONE;
          r_rank   = pos_rank;
          r_key    = req_key_q;
        end
      end
      OP_LOWER: begin
        r_rank = pos_rank;
        if (lookup.present) begin
          r_status = STAT_DONE;
          r_key    = req_key_q;
        end
      end
      OP_SELECT: begin
        if (in_range) begin
          r_status = STAT_DONE;
          r_rank   = RANK_W'(req_index_q);
          r_key    = lookup.sel_key;
        end
      end
      OP_CLEAR: begin
        r_status = STAT_DONE;
        r_count  = '0;
      end
      default: begin
        r_status = STAT_NO_EFFECT;
      end
    endcase
  end

  // Next state and cell commands
  always_comb begin
    state_d = state_q;
    cmd     = '0;
    commit  = 1'b0;
    count_d = count_q;
    unique case (state_q)
      CTL_IDLE: begin
        if (accept) begin
          state_d = CTL_CMP;
        end
      end
      CTL_CMP: begin
        cmd.cmp = 1'b1;
        state_d = CTL_RES;
      end
      CTL_RES: begin
        if (out_free) begin
          commit  = 1'b1;
          cmd.ins = r_ins;
          cmd.ers = r_ers;
          count_d = r_count;
          state_d = CTL_IDLE;
        end
      end
      default: begin
        state_d = CTL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTL_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the request and load the output register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= operation_i;
      req_key_q   <= key_i;
      req_index_q <= index_i;
    end
    if (commit) begin
      status_q    <= r_status;
      rank_q      <= r_rank;
      key_out_q   <= r_key;
      out_count_q <= COUNT_W'(r_count);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign rank_o      = rank_q;
  assign key_out_o   = key_out_q;
  assign count_o     = out_count_q;

  // Checks
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] eq_vec;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt_vec[i] = flags[i].lt;
      eq_vec[i] = flags[i].eq;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("key count above capacity");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> (!out_valid_q || !out_stall_i))
    else $error("result written over a waiting result");

  a_commit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (state_q == CTL_IDLE && out_valid_q))
    else $error("commit did not return to idle with a result");

  a_lt_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CTL_RES) |-> ((lt_vec & (lt_vec + 1'b1)) == '0))
    else $error("smaller-key flags not a run from cell zero");

  a_eq_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CTL_RES) |-> $onehot0(eq_vec))
    else $error("key held in more than one cell");

endmodule

// ----- rtl/osrs_cell.sv -----
// One storage cell of the sorted row: holds a key, compares it and shifts with its neighbors.
module osrs_cell import osrs_pkg::*; (
  input  logic                clk_i,
  input  logic [IDX_W-1:0]    cell_idx_i,
  input  logic [CNT_W-1:0]    count_i,
  input  logic [KEY_BITS-1:0] req_key_i,
  input  logic [INDEX_W-1:0]  req_index_i,
  input  cell_cmd_t           cmd_i,
  input  logic [KEY_BITS-1:0] left_key_i,
  input  logic                left_lt_i,
  input  logic [KEY_BITS-1:0] right_key_i,
  output logic [KEY_BITS-1:0] key_o,
  output cell_flags_t         flags_o
);

  logic [KEY_BITS-1:0] key_q, key_d;
  cell_flags_t         flags_q, flags_d;
  logic                occupied;

  // Compare the held key against the request
  always_comb begin
    occupied    = CNT_W'(cell_idx_i) < count_i;
    flags_d.lt  = occupied && (key_q < req_key_i);
    flags_d.eq  = occupied && (key_q == req_key_i);
    flags_d.sel = WIDE_W'(req_index_i) == WIDE_W'(cell_idx_i);
  end

  // Open a slot for insert or close the gap for erase
  always_comb begin
    key_d = key_q;
    if (cmd_i.ins && !flags_q.lt) begin
      key_d = left_lt_i ? req_key_i : left_key_i;
    end else if (cmd_i.ers && !flags_q.lt) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      flags_q <= flags_d;
    end
    key_q <= key_d;
  end

  assign key_o   = key_q;
  assign flags_o = flags_q;

endmodule

// ----- rtl/osrs_resolve.sv -----
// Gathers the row's compare flags into a sorted position, a hit and a selected key.
module osrs_resolve import osrs_pkg::*; (
  input  cell_flags_t [CAPACITY-1:0]               flags_i,
  input  logic        [CAPACITY-1:0][KEY_BITS-1:0] keys_i,
  input  logic        [CNT_W-1:0]                  count_i,
  output lookup_t                                  lookup_o
);

  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] prev_lt;
  logic [CAPACITY-1:0] eq_vec;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt_vec[i] = flags_i[i].lt;
      eq_vec[i] = flags_i[i].eq;
    end
  end

  // The lt flags form a run from cell zero; the position is where it ends
  assign prev_lt = {lt_vec[CAPACITY-2:0], 1'b1};

  always_comb begin
    lookup_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (prev_lt[i] && !lt_vec[i]) begin
        lookup_o.pos = lookup_o.pos | CNT_W'(i);
      end
      if (flags_i[i].sel) begin
        lookup_o.sel_key = lookup_o.sel_key | keys_i[i];
      end
    end
    // Every held key smaller and the row full: position is the count
    if (lt_vec[CAPACITY-1]) begin
      lookup_o.pos = count_i;
    end
    lookup_o.present = |eq_vec;
  end

endmodule
